FILE: hw/rtl/lkd_pkg.sv
// Shared types, register codes and reset values for the ladder keypad debounce block.
`timescale 1ns / 1ps

package lkd_pkg;

	localparam int unsigned SAMPLE_W = 8;
	localparam int unsigned CODE_W   = 3;
	localparam int unsigned MAP_W    = 15;
	localparam int unsigned NUM_SW   = 5;
	localparam int unsigned ADDR_W   = 5;
	localparam int unsigned DATA_W   = 32;
	localparam int unsigned REG_IDX_W = 3;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_NONE_THR = 3'd0,
		REG_LIMIT_1  = 3'd1,
		REG_LIMIT_2  = 3'd2,
		REG_LIMIT_3  = 3'd3,
		REG_LIMIT_4  = 3'd4,
		REG_LIMIT_5  = 3'd5,
		REG_KEY_MAP  = 3'd6
	} reg_idx_t;

	localparam logic [SAMPLE_W-1:0] NONE_THR_RST = 8'd245;
	localparam logic [SAMPLE_W-1:0] LIMIT_1_RST  = 8'd30;
	localparam logic [SAMPLE_W-1:0] LIMIT_2_RST  = 8'd80;
	localparam logic [SAMPLE_W-1:0] LIMIT_3_RST  = 8'd120;
	localparam logic [SAMPLE_W-1:0] LIMIT_4_RST  = 8'd180;
	localparam logic [SAMPLE_W-1:0] LIMIT_5_RST  = 8'd230;
	localparam logic [MAP_W-1:0]    KEY_MAP_RST  = 15'd22667;

	localparam logic [CODE_W-1:0] NO_KEY    = 3'd0;
	localparam logic [CODE_W-1:0] KEY_FIRST = 3'd1;
	localparam logic [CODE_W-1:0] KEY_LAST  = 3'd5;

	typedef struct packed {
		logic [SAMPLE_W-1:0]             none_thr;
		logic [NUM_SW-1:0][SAMPLE_W-1:0] limit;
		logic [MAP_W-1:0]                key_map;
	} cfg_t;

	typedef struct packed {
		logic              is_press;
		logic [CODE_W-1:0] key_code;
		logic              last;
	} evt_t;

	typedef struct packed {
		logic [1:0] cnt;
		evt_t       e0;
		evt_t       e1;
	} evt_pair_t;

	function automatic logic is_real_key(input logic [CODE_W-1:0] code);
		return code inside {[KEY_FIRST:KEY_LAST]};
	endfunction

endpackage

FILE: hw/rtl/lkd_cfg_regs.sv
// APB register file holding the thresholds and the switch to key map.
`timescale 1ns / 1ps

module lkd_cfg_regs
	import lkd_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [ADDR_W-1:0]        paddr,
	input  logic [DATA_W-1:0]        pwdata,
	output logic [DATA_W-1:0]        prdata,
	output logic                     pready,
	output cfg_t                     cfg
);

	logic           wr_en;
	reg_idx_t       idx;
	cfg_t           cfg_q;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.none_thr <= NONE_THR_RST;
			cfg_q.limit[0] <= LIMIT_1_RST;
			cfg_q.limit[1] <= LIMIT_2_RST;
			cfg_q.limit[2] <= LIMIT_3_RST;
			cfg_q.limit[3] <= LIMIT_4_RST;
			cfg_q.limit[4] <= LIMIT_5_RST;
			cfg_q.key_map  <= KEY_MAP_RST;
		end else if (wr_en) begin
			case (idx)
				REG_NONE_THR: cfg_q.none_thr <= pwdata[SAMPLE_W-1:0];
				REG_LIMIT_1:  cfg_q.limit[0] <= pwdata[SAMPLE_W-1:0];
				REG_LIMIT_2:  cfg_q.limit[1] <= pwdata[SAMPLE_W-1:0];
				REG_LIMIT_3:  cfg_q.limit[2] <= pwdata[SAMPLE_W-1:0];
				REG_LIMIT_4:  cfg_q.limit[3] <= pwdata[SAMPLE_W-1:0];
				REG_LIMIT_5:  cfg_q.limit[4] <= pwdata[SAMPLE_W-1:0];
				REG_KEY_MAP:  cfg_q.key_map  <= pwdata[MAP_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_NONE_THR: prdata = DATA_W'(cfg_q.none_thr);
			REG_LIMIT_1:  prdata = DATA_W'(cfg_q.limit[0]);
			REG_LIMIT_2:  prdata = DATA_W'(cfg_q.limit[1]);
			REG_LIMIT_3:  prdata = DATA_W'(cfg_q.limit[2]);
			REG_LIMIT_4:  prdata = DATA_W'(cfg_q.limit[3]);
			REG_LIMIT_5:  prdata = DATA_W'(cfg_q.limit[4]);
			REG_KEY_MAP:  prdata = DATA_W'(cfg_q.key_map);
			default:      prdata = '0;
		endcase
	end

endmodule

FILE: hw/rtl/lkd_classify.sv
// Sample classifier: threshold compares and switch to key code lookup.
`timescale 1ns / 1ps

module lkd_classify
	import lkd_pkg::*;
(
	input  logic [SAMPLE_W-1:0] sample,
	input  cfg_t                cfg,
	output logic [CODE_W-1:0]   code
);

	logic [NUM_SW-1:0] hit;

	always_comb begin
		for (int n = 0; n < NUM_SW; n++) begin
			hit[n] = (sample <= cfg.limit[n]);
		end
	end

	// The first bound that the sample does not exceed wins.
	always_comb begin
		code = NO_KEY;
		if (sample < cfg.none_thr) begin
			if (hit[0]) begin
				code = cfg.key_map[2:0];
			end else if (hit[1]) begin
				code = cfg.key_map[5:3];
			end else if (hit[2]) begin
				code = cfg.key_map[8:6];
			end else if (hit[3]) begin
				code = cfg.key_map[11:9];
			end else if (hit[4]) begin
				code = cfg.key_map[14:12];
			end
		end
	end

endmodule

FILE: hw/rtl/lkd_event_q.sv
// Two-slot output buffer that takes up to two events at once and sends one per cycle while m_tready is high.
`timescale 1ns / 1ps

module lkd_event_q
	import lkd_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  evt_pair_t pair,
	output logic      room,
	output logic      m_tvalid,
	input  logic      m_tready,
	output evt_t      m_evt
);

	logic o_valid_q;
	logic p_valid_q;
	evt_t o_evt_q;
	evt_t p_evt_q;
	logic pop;

	assign pop      = o_valid_q & m_tready;
	assign room     = !p_valid_q && (!o_valid_q || pop);
	assign m_tvalid = o_valid_q;
	assign m_evt    = o_evt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			o_valid_q <= 1'b0;
			p_valid_q <= 1'b0;
		end else if (push) begin
			o_valid_q <= (pair.cnt != 2'd0);
			p_valid_q <= (pair.cnt == 2'd2);
		end else if (pop) begin
			o_valid_q <= p_valid_q;
			p_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			o_evt_q <= pair.e0;
			p_evt_q <= pair.e1;
		end else if (pop) begin
			o_evt_q <= p_evt_q;
		end
	end

endmodule

FILE: hw/rtl/ladder_keypad_debounce_events_core.sv
// Top level of the ladder keypad classifier, debouncer and press/release event source.
`timescale 1ns / 1ps

// The slave stream takes one 8-bit converter sample per item. Each sample is
// classified against the none threshold and five switch bounds, mapped to a
// key code, and debounced over two equal codes in a row. When the debounced
// key differs from the held key the master stream sends a release for the old
// key if it is a real key and then a press for the new one if it is a real
// key; tlast marks the final event of a sample. A sample is registered at the
// input and processed into the output register when the buffer has room, so
// the input register and then the output register lie between acceptance and
// m_tvalid. A sample that causes a release and a press fills both buffer slots;
// the single output register sends one event per cycle while m_tready is high.
// A stalled master side holds the events in a two-slot buffer; the input
// register then fills and s_tready drops. Reset clears the debounce state to no
// key, empties the buffers and loads the register defaults. The user must
// write configuration over APB while the block is idle; it does not enforce this.

module ladder_keypad_debounce_events_core
	import lkd_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [7:0]          s_tdata,   // [7:0] adc_sample
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [7:0]          m_tdata,   // [2:0] key_code, [7:3] zero
	output logic                m_tuser,   // [0] is_press
	output logic                m_tlast,   // last_event
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [ADDR_W-1:0]   paddr,
	input  logic [DATA_W-1:0]   pwdata,
	output logic [DATA_W-1:0]   prdata,
	output logic                pready
);

	cfg_t                cfg;
	logic                s1_valid_q;
	logic [SAMPLE_W-1:0] sample_s1;
	logic [CODE_W-1:0]   now_code;
	logic [CODE_W-1:0]   prev_q;
	logic [CODE_W-1:0]   stable_q;
	logic [CODE_W-1:0]   held_q;
	logic [CODE_W-1:0]   stable_nxt;
	logic                room;
	logic                process;
	logic                rel;
	logic                prs;
	evt_pair_t           pair;
	evt_t                m_evt;

	lkd_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	lkd_classify u_cls (
		.sample (sample_s1),
		.cfg    (cfg),
		.code   (now_code)
	);

	assign process  = s1_valid_q & room;
	assign s_tready = !s1_valid_q || process;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			s1_valid_q <= 1'b1;
		end else if (process) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			sample_s1 <= s_tdata[SAMPLE_W-1:0];
		end
	end

	always_comb begin
		stable_nxt = (now_code == prev_q) ? now_code : stable_q;
		rel        = (stable_nxt != held_q) && is_real_key(held_q);
		prs        = (stable_nxt != held_q) && is_real_key(stable_nxt);
		pair.e0    = '0;
		pair.e1    = '0;
		pair.cnt   = 2'd0;
		if (rel && prs) begin
			pair.cnt         = 2'd2;
			pair.e0.is_press = 1'b0;
			pair.e0.key_code = held_q;
			pair.e0.last     = 1'b0;
			pair.e1.is_press = 1'b1;
			pair.e1.key_code = stable_nxt;
			pair.e1.last     = 1'b1;
		end else if (rel) begin
			pair.cnt         = 2'd1;
			pair.e0.is_press = 1'b0;
			pair.e0.key_code = held_q;
			pair.e0.last     = 1'b1;
		end else if (prs) begin
			pair.cnt         = 2'd1;
			pair.e0.is_press = 1'b1;
			pair.e0.key_code = stable_nxt;
			pair.e0.last     = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q   <= NO_KEY;
			stable_q <= NO_KEY;
			held_q   <= NO_KEY;
		end else if (process) begin
			prev_q   <= now_code;
			stable_q <= stable_nxt;
			held_q   <= stable_nxt;
		end
	end

	lkd_event_q u_evq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (process),
		.pair     (pair),
		.room     (room),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_evt    (m_evt)
	);

	assign m_tdata = {5'd0, m_evt.key_code};
	assign m_tuser = m_evt.is_press;
	assign m_tlast = m_evt.last;

	a_real_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[2:0] >= KEY_FIRST && m_tdata[2:0] <= KEY_LAST))
		else $error("event carries a code that is not a real key");

	a_press_follows: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=> m_tvalid && m_tuser && m_tlast)
		else $error("release that is not last must be followed by a press");

	a_held_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!process |=> $stable(held_q))
		else $error("held key changed without a processed sample");

	a_release_old: assert property (@(posedge clk) disable iff (!arst_n)
		process && pair.cnt != 2'd0 |=> held_q != $past(held_q))
		else $error("event issued without a change of held key");

endmodule
